// ===== hw/rtl/cdg_pkg.sv =====
// Shared types and constants of the color distance gradient block.
// Used by cdg_root, cdg_datapath, cdg_ctrl and color_distance_gradient.
package cdg_pkg;

  localparam int RootInW  = 26;
  localparam int RootOutW = 13;
  localparam int RootStepW = 4;
  localparam logic [RootStepW-1:0] ROOT_LAST_STEP = 4'd12;

  // configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  // which result of the current input word is being built
  localparam logic [1:0] JOB_ABOVE = 2'd0;
  localparam logic [1:0] JOB_LEFT  = 2'd1;
  localparam logic [1:0] JOB_HERE  = 2'd2;

  // neighbor selection for the line store read
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  typedef struct packed {
    logic       accept;
    logic       load_job;
    logic [1:0] job;
    logic [1:0] rd_sel;
    logic       cap_a;
    logic       cap_b;
    logic       root_start;
    logic       root_mag;
    logic       store_gx;
    logic       store_gy;
    logic       emit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] jobs;
    logic       need_x;
    logic       need_y;
    logic       root_busy;
    logic       out_free;
  } status_t;

endpackage

// ===== hw/rtl/cdg_root.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on cdg_pkg for widths.
module cdg_root (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cdg_pkg::RootInW-1:0]   radicand,
  output logic [cdg_pkg::RootOutW-1:0]  root,
  output logic                          busy
);
  import cdg_pkg::*;

  logic [RootInW-1:0]   rad;
  logic [RootOutW+2:0]  rem;
  logic [RootStepW-1:0] step;
  logic [RootOutW+2:0]  rem_sh;
  logic [RootOutW+2:0]  trial;

  always_comb begin
    rem_sh = {rem[RootOutW:0], rad[RootInW-1 -: 2]};
    trial  = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == ROOT_LAST_STEP) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RootInW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RootOutW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RootOutW-2:0], 1'b0};
      end
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("root unit did not start");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= ROOT_LAST_STEP)
    else $error("root step counter overran");
  a_done_steps: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(step) == ROOT_LAST_STEP)
    else $error("root finished early");

endmodule

// ===== hw/rtl/cdg_datapath.sv =====
// Datapath: frame counters, config registers, three-row line store,
// distance squares, shared square root and the output register.
// Depends on cdg_pkg and cdg_root.
module cdg_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  cdg_pkg::cmd_t    cmd,
  output cdg_pkg::status_t status,
  input  logic [23:0]      in_data,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [10:0]      cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [55:0]      out_data,
  output logic             out_last,
  output logic             out_user
);
  import cdg_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int Depth = 3 * MAX_WIDTH;
  localparam int AW = $clog2(Depth);
  localparam int ResetW = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int ResetH = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  logic [CW-1:0] w_last, col_cnt, acc_col, t_col;
  logic [RW-1:0] h_last, row_cnt, acc_row, t_row;
  logic [1:0]    row_slot, acc_slot, t_slot;
  logic [1:0]    prev_slot, up_slot, down_slot;
  logic [23:0]   mem [0:Depth-1];
  logic [23:0]   rd_data, pa, pb;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [1:0]    rd_slot;
  logic [CW-1:0] rd_col;
  logic [8:0]    gx, gy;
  logic [17:0]   dist_sum;
  logic [18:0]   mag_sum;
  logic [RootInW-1:0]  radicand;
  logic [RootOutW-1:0] root;
  logic          root_busy;
  logic          border_row;
  logic [12:0]   w_clamp, h_clamp;
  logic [31:0]   row_ext, col_ext;

  function automatic logic [AW-1:0] slot_base(input logic [1:0] s);
    logic [AW-1:0] b;
    case (s)
      2'd0:    b = '0;
      2'd1:    b = AW'(MAX_WIDTH);
      default: b = AW'(2 * MAX_WIDTH);
    endcase
    return b;
  endfunction

  function automatic logic [12:0] clamp_last(input logic [10:0] v, input int mx);
    logic [12:0] v13;
    logic [12:0] r;
    v13 = 13'(v);
    if (v13 < 13'd3) r = 13'd2;
    else if (v13 > 13'(mx)) r = 13'(mx - 1);
    else r = v13 - 13'd1;
    return r;
  endfunction

  function automatic logic [15:0] sq8(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a >= b) ? a - b : b - a;
    return 16'(d) * 16'(d);
  endfunction

  always_comb begin
    w_clamp = clamp_last(cfg_data, MAX_WIDTH);
    h_clamp = clamp_last(cfg_data, MAX_HEIGHT);
    border_row = (row_cnt == '0) || (row_cnt == h_last);
    status.jobs[JOB_ABOVE] = row_cnt >= RW'(2);
    status.jobs[JOB_LEFT]  = border_row && (col_cnt >= CW'(2));
    status.jobs[JOB_HERE]  = border_row && ((col_cnt == '0) || (col_cnt == w_last));
    status.need_x    = (t_col != '0) && (t_col != w_last);
    status.need_y    = (t_row != '0) && (t_row != h_last);
    status.root_busy = root_busy;
    status.out_free  = !out_valid || out_ready;

    prev_slot = (acc_slot == 2'd0) ? 2'd2 : acc_slot - 2'd1;
    up_slot   = (t_slot == 2'd0) ? 2'd2 : t_slot - 2'd1;
    down_slot = (t_slot == 2'd2) ? 2'd0 : t_slot + 2'd1;
    case (cmd.rd_sel)
      DIR_RIGHT: begin rd_slot = t_slot;    rd_col = t_col + 1'b1; end
      DIR_LEFT:  begin rd_slot = t_slot;    rd_col = t_col - 1'b1; end
      DIR_DOWN:  begin rd_slot = down_slot; rd_col = t_col;        end
      default:   begin rd_slot = up_slot;   rd_col = t_col;        end
    endcase
    rd_addr = slot_base(rd_slot) + AW'(rd_col);
    wr_addr = slot_base(row_slot) + AW'(col_cnt);

    dist_sum = 18'(sq8(pa[7:0], pb[7:0])) + 18'(sq8(pa[15:8], pb[15:8]))
             + 18'(sq8(pa[23:16], pb[23:16]));
    mag_sum  = 19'(18'(gx) * 18'(gx)) + 19'(18'(gy) * 18'(gy));
    radicand = cmd.root_mag ? {1'b0, mag_sum, 6'd0} : RootInW'(dist_sum);
    row_ext  = 32'(t_row);
    col_ext  = 32'(t_col);
  end

  cdg_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (radicand),
    .root     (root),
    .busy     (root_busy)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) mem[wr_addr] <= in_data;
    rd_data <= mem[rd_addr];
  end

  // frame position and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      row_slot <= 2'd0;
      w_last   <= CW'(ResetW - 1);
      h_last   <= RW'(ResetH - 1);
    end else begin
      if (cmd.accept) begin
        if (col_cnt == w_last) begin
          col_cnt <= '0;
          if (row_cnt == h_last) begin
            row_cnt  <= '0;
            row_slot <= 2'd0;
          end else begin
            row_cnt  <= row_cnt + 1'b1;
            row_slot <= (row_slot == 2'd2) ? 2'd0 : row_slot + 2'd1;
          end
        end else begin
          col_cnt <= col_cnt + 1'b1;
        end
      end
      if (cfg_write && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
        col_cnt  <= '0;
        row_cnt  <= '0;
        row_slot <= 2'd0;
        if (cfg_index == REG_FRAME_WIDTH) w_last <= w_clamp[CW-1:0];
        else h_last <= h_clamp[RW-1:0];
      end
    end
  end

  // job target and operands
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc_row  <= row_cnt;
      acc_col  <= col_cnt;
      acc_slot <= row_slot;
    end
    if (cmd.load_job) begin
      gx <= '0;
      gy <= '0;
      case (cmd.job)
        JOB_ABOVE: begin t_row <= acc_row - 1'b1; t_col <= acc_col;        t_slot <= prev_slot; end
        JOB_LEFT:  begin t_row <= acc_row;        t_col <= acc_col - 1'b1; t_slot <= acc_slot;  end
        default:   begin t_row <= acc_row;        t_col <= acc_col;        t_slot <= acc_slot;  end
      endcase
    end
    if (cmd.cap_a) pa <= rd_data;
    if (cmd.cap_b) pb <= rd_data;
    if (cmd.store_gx) gx <= root[8:0];
    if (cmd.store_gy) gy <= root[8:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {5'd0, root, gy, gx, col_ext[9:0], row_ext[9:0]};
      out_last <= cmd.last;
      out_user <= (t_row == h_last) && (t_col == w_last);
    end
  end

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_user |-> out_last)
    else $error("frame end not on last result of its word");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !out_valid || out_ready)
    else $error("result overwritten");
  a_store_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.store_gx || cmd.store_gy) |-> !root_busy)
    else $error("gradient stored from running root");

endmodule

// ===== hw/rtl/cdg_ctrl.sv =====
// Controller: sequences store reads, square roots and result words
// for each accepted pixel. Depends on cdg_pkg.
module cdg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cdg_pkg::status_t status,
  output cdg_pkg::cmd_t    cmd
);
  import cdg_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PLAN  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_RDA   = 4'd3;
  localparam logic [3:0] S_RDB   = 4'd4;
  localparam logic [3:0] S_CAPB  = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_ROOT  = 4'd7;
  localparam logic [3:0] S_MSUM  = 4'd8;
  localparam logic [3:0] S_MROOT = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state, state_next;
  logic [2:0] pend, pend_next;
  logic       axis_y, axis_y_next;

  always_comb begin
    state_next  = state;
    pend_next   = pend;
    axis_y_next = axis_y;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          pend_next  = status.jobs;
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        if (pend == 3'd0) begin
          state_next = S_IDLE;
        end else begin
          cmd.load_job = 1'b1;
          if (pend[JOB_ABOVE]) begin
            cmd.job = JOB_ABOVE;
            pend_next[JOB_ABOVE] = 1'b0;
          end else if (pend[JOB_LEFT]) begin
            cmd.job = JOB_LEFT;
            pend_next[JOB_LEFT] = 1'b0;
          end else begin
            cmd.job = JOB_HERE;
            pend_next[JOB_HERE] = 1'b0;
          end
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        axis_y_next = !status.need_x;
        if (status.need_x || status.need_y) state_next = S_RDA;
        else state_next = S_MSUM;
      end
      S_RDA: begin
        cmd.rd_sel = axis_y ? DIR_DOWN : DIR_RIGHT;
        state_next = S_RDB;
      end
      S_RDB: begin
        cmd.rd_sel = axis_y ? DIR_UP : DIR_LEFT;
        cmd.cap_a  = 1'b1;
        state_next = S_CAPB;
      end
      S_CAPB: begin
        cmd.cap_b  = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.root_start = 1'b1;
        state_next     = S_ROOT;
      end
      S_ROOT: begin
        if (!status.root_busy) begin
          cmd.store_gx = !axis_y;
          cmd.store_gy = axis_y;
          if (!axis_y && status.need_y) begin
            axis_y_next = 1'b1;
            state_next  = S_RDA;
          end else begin
            state_next = S_MSUM;
          end
        end
      end
      S_MSUM: begin
        cmd.root_start = 1'b1;
        cmd.root_mag   = 1'b1;
        state_next     = S_MROOT;
      end
      S_MROOT: begin
        if (!status.root_busy) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = (pend == 3'd0);
          state_next = S_PLAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pend   <= 3'd0;
      axis_y <= 1'b0;
    end else begin
      state  <= state_next;
      pend   <= pend_next;
      axis_y <= axis_y_next;
    end
  end

  a_accept_plan: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == S_PLAN)
    else $error("accept did not start planning");
  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.last |=> state == S_PLAN && pend == 3'd0)
    else $error("last result with work pending");
  a_pend_shrinks: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> $countones(pend) <= $countones($past(pend)))
    else $error("pending results grew mid-word");

endmodule

// ===== hw/rtl/color_distance_gradient.sv =====
// Color gradient magnitude over a raster BGR stream; top level.
// Depends on cdg_pkg, cdg_ctrl, cdg_datapath (with cdg_root).
//
// Pixels enter in raster order and each frame position gets one result,
// sent once its neighbors are stored: at the frame end one pixel yields up
// to three words. One pixel word at a time is processed: it is accepted
// and planned, then each result is set up, takes for each gradient axis it
// needs two line store reads with their captures, the root start and the
// 13-step square root, then the magnitude root, and is sent once the output
// is free. The shared 2-bits-per-cycle square-root unit sets the pace of
// this work. Writing frame_width or frame_height restarts the frame at
// row 0, column 0.
module color_distance_gradient #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // blue[7:0], green[15:8], red[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_row[9:0], pixel_col[19:10], grad_x_twice[28:20],
  // grad_y_twice[37:29], magnitude_q4[50:38], zero[55:51]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,  // end_of_run
  output logic        m_axis_tuser,  // end_of_frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import cdg_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  cdg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cdg_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_user  (m_axis_tuser)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for color_distance_gradient: a queue-fed pixel driver,
// a result monitor and an in-bench gradient predictor. Depends on cdg_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cdg_pkg::*;

  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  col;
    logic [8:0]  gx;
    logic [8:0]  gy;
    logic [12:0] mag;
    logic        eor;
    logic        eof;
  } grad_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  color_distance_gradient i_dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [23:0] line_mem [3*1024];
  int unsigned cur_row, cur_col, width_reg, height_reg;
  grad_t expected_grads[$];
  logic [23:0] pixel_queue[$];
  int errors = 0;
  longint cycles = 0;
  bit no_idle = 0;
  bit in_taken = 0;
  int hold_off = 0;

  function automatic int unsigned int_sqrt(int unsigned v);
    int unsigned res = 0, b = 1 << 30;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned clamp_dim(int unsigned v);
    return v < 3 ? 3 : (v > 1024 ? 1024 : v);
  endfunction

  function automatic int unsigned color_dist(logic [23:0] p, logic [23:0] q);
    int unsigned s = 0;
    int d;
    for (int k = 0; k < 3; k++) begin
      d = int'(p[8*k+:8]) - int'(q[8*k+:8]);
      s += d * d;
    end
    return int_sqrt(s);
  endfunction

  function automatic grad_t make_grad(int unsigned r, int unsigned c,
                                      int unsigned w, int unsigned h);
    grad_t g;
    int unsigned gx = 0, gy = 0;
    if (c != 0 && c != w - 1)
      gx = color_dist(line_mem[(r % 3)*1024 + c + 1], line_mem[(r % 3)*1024 + c - 1]);
    if (r != 0 && r != h - 1)
      gy = color_dist(line_mem[((r + 1) % 3)*1024 + c], line_mem[((r - 1) % 3)*1024 + c]);
    g.row = 10'(r); g.col = 10'(c); g.gx = 9'(gx); g.gy = 9'(gy);
    g.mag = 13'(int_sqrt(64 * (gx*gx + gy*gy)));
    g.eor = 1'b0;
    g.eof = (r == h - 1 && c == w - 1);
    return g;
  endfunction

  task automatic predict_pixel(logic [23:0] px);
    int unsigned w, h, r, c, n;
    bit brow;
    grad_t g;
    w = clamp_dim(width_reg); h = clamp_dim(height_reg);
    r = cur_row; c = cur_col; n = 0;
    brow = (r == 0 || r == h - 1);
    line_mem[(r % 3)*1024 + c] = px;
    if (r >= 2 && r - 1 <= h - 2) begin
      expected_grads.push_back(make_grad(r - 1, c, w, h)); n++;
    end
    if (brow && c >= 2 && c <= w - 1) begin
      expected_grads.push_back(make_grad(r, c - 1, w, h)); n++;
    end
    if (brow && (c == 0 || c == w - 1)) begin
      expected_grads.push_back(make_grad(r, c, w, h)); n++;
    end
    if (n > 0) begin
      g = expected_grads.pop_back();
      g.eor = 1'b1;
      expected_grads.push_back(g);
    end
    c++;
    if (c >= w) begin
      c = 0; r++;
      if (r >= h) r = 0;
    end
    cur_row = r; cur_col = c;
  endtask

  // driver: hold an offered word until taken, idle at random
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_taken) begin
        if (pixel_queue.size() > 0 && (no_idle || $urandom_range(99) >= 16)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pixel_queue[0];
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      in_taken = 1'b0;
    end
  end

  // receiver: long hold-off when asked, else idle at random
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 16);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    grad_t e, a;
    cycles++;
    if (cycles > 64'd3000000) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      predict_pixel(s_axis_tdata);
      void'(pixel_queue.pop_front());
      in_taken = 1'b1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      a.row = m_axis_tdata[9:0];
      a.col = m_axis_tdata[19:10];
      a.gx  = m_axis_tdata[28:20];
      a.gy  = m_axis_tdata[37:29];
      a.mag = m_axis_tdata[50:38];
      a.eor = m_axis_tlast;
      a.eof = m_axis_tuser;
      if (expected_grads.size() == 0) begin
        $error("unexpected result word row %0d col %0d", a.row, a.col);
        errors++;
      end else begin
        e = expected_grads.pop_front();
        if (a.row != e.row) begin $error("pixel_row exp %0d got %0d", e.row, a.row); errors++; end
        if (a.col != e.col) begin $error("pixel_col exp %0d got %0d", e.col, a.col); errors++; end
        if (a.gx != e.gx) begin $error("grad_x_twice exp %0d got %0d", e.gx, a.gx); errors++; end
        if (a.gy != e.gy) begin $error("grad_y_twice exp %0d got %0d", e.gy, a.gy); errors++; end
        if (a.mag != e.mag) begin $error("magnitude_q4 exp %0d got %0d", e.mag, a.mag); errors++; end
        if (a.eor != e.eor) begin $error("end_of_run exp %0d got %0d", e.eor, a.eor); errors++; end
        if (a.eof != e.eof) begin $error("end_of_frame exp %0d got %0d", e.eof, a.eof); errors++; end
      end
    end
  end

  task automatic drain();
    while (pixel_queue.size() > 0 || s_axis_tvalid || expected_grads.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = 32'(val); else height_reg = 32'(val);
    cur_row = 0; cur_col = 0;
  endtask

  function automatic logic [23:0] rand_pixel(int mode);
    case (mode)
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return {$urandom_range(255) > 127 ? 8'hFF : 8'h00,
                 $urandom_range(255) > 127 ? 8'hFF : 8'h00,
                 $urandom_range(255) > 127 ? 8'hFF : 8'h00};
      default: return 24'($urandom());
    endcase
  endfunction

  // frame setups: width, height; extremes, out-of-range and small frames
  initial begin
    int unsigned ws[7] = '{3, 0, 5, 4, 7, 2047, 3};
    int unsigned hs[7] = '{3, 3, 4, 2, 6, 3, 1024};
    int unsigned w, h, npx, total;
    width_reg = 640; height_reg = 480; cur_row = 0; cur_col = 0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    // directed: two 3x3 frames of extremes, a checkerboard of black and white and a white center on black
    write_reg(REG_FRAME_WIDTH, 11'd3);
    write_reg(REG_FRAME_HEIGHT, 11'd3);
    for (int i = 0; i < 9; i++) pixel_queue.push_back(i % 2 ? 24'hFFFFFF : 24'h000000);
    for (int i = 0; i < 9; i++) pixel_queue.push_back(i == 4 ? 24'hFFFFFF : 24'h000000);
    drain();
    total = 0;
    for (int s = 0; s < 7; s++) begin
      write_reg(REG_FRAME_WIDTH, 11'(ws[s]));
      write_reg(REG_FRAME_HEIGHT, 11'(hs[s]));
      w = clamp_dim(ws[s]); h = clamp_dim(hs[s]);
      npx = (s >= 5) ? w * h / 4 : 2 * w * h;  // partial frame on the largest sizes
      if (npx > 60) npx = 60;
      no_idle = (s == 2);
      if (s == 3) hold_off = 600;
      for (int i = 0; i < npx; i++) pixel_queue.push_back(rand_pixel($urandom_range(5)));
      total += npx;
      drain();
    end
    no_idle = 0;
    $display("covered %0d random pixels over seven frame shapes, including clamped sizes",
             total);
    $display("and a long output stall that backs up the pixel input");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/cdg_pkg.sv
hw/rtl/cdg_root.sv
hw/rtl/cdg_datapath.sv
hw/rtl/cdg_ctrl.sv
hw/rtl/color_distance_gradient.sv
bench/tb_top.sv
